>>> rtl/fcop_pkg.sv
`timescale 1ns / 1ps
package fcop_pkg;

  localparam int SENSOR_COUNT  = 8;
  localparam int FRACTION_BITS = 4;

  localparam int SENSOR_SLOTS = 8;
  localparam int IDX_W        = 3;
  localparam int ADC_W        = 10;
  localparam int TOTAL_W      = 13;
  localparam int ACC_W        = 20;                  // signed weighted sums
  localparam int DIV_W        = ACC_W - 1 + FRACTION_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
  localparam int REM_W        = TOTAL_W + 1;
  localparam int COPX_W       = 11;
  localparam int COPY_W       = 12;

  // sensor positions in mm
  localparam logic signed [7:0] POS_X [SENSOR_SLOTS] = '{
    -8'sd50, 8'sd50, -8'sd25, 8'sd25, -8'sd30, 8'sd30, -8'sd15, 8'sd15
  };
  localparam logic signed [7:0] POS_Y [SENSOR_SLOTS] = '{
    -8'sd100, -8'sd100, -8'sd50, -8'sd50, 8'sd0, 8'sd0, 8'sd50, 8'sd50
  };

  typedef struct packed {
    logic [IDX_W-1:0] sensor_index;
    logic [7:0]       reply_high;
    logic [7:0]       reply_low;
    logic             read_ok;
    logic             end_of_frame;
  } fcop_in_t;

  typedef struct packed {
    logic signed [COPX_W-1:0] cop_x;
    logic signed [COPY_W-1:0] cop_y;
    logic [TOTAL_W-1:0]       total_counts;
    logic                     contact;
  } fcop_out_t;

endpackage

>>> rtl/foot_center_of_pressure_unit.sv
`timescale 1ns / 1ps
// Update words are accepted while idle; a word without end of frame gives no result.
// End-of-frame word: SENSOR_COUNT store reads, then two parallel bit-serial
// dividers of DIV_W bits when there is contact (total above the threshold);
// without contact the dividers are skipped and a zero position is put out.
// Input is stalled from that accept until the result is loaded into out_word.
// Synchronous reset: readings read as zero, threshold 10, no result pending.
module foot_center_of_pressure_unit
  import fcop_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [TOTAL_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  fcop_in_t           in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output fcop_out_t          out_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_CHECK,
    ST_DIV,
    ST_PUT
  } state_t;

  state_t                   state_r;
  logic [TOTAL_W-1:0]       thr_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic [IDX_W-1:0]         acc_idx_r;
  logic                     acc_en_r;
  logic [TOTAL_W-1:0]       total_r;
  logic signed [ACC_W-1:0]  acc_x_r;
  logic signed [ACC_W-1:0]  acc_y_r;
  logic                     contact_r;
  logic                     neg_x_r;
  logic                     neg_y_r;
  logic                     out_valid_r;
  fcop_out_t                out_word_r;

  logic                     in_acc;
  logic                     ram_we;
  logic [ADC_W-1:0]         rd_data;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [ACC_W-1:0]  prod_y;
  logic [ACC_W-1:0]         abs_x;
  logic [ACC_W-1:0]         abs_y;
  logic [DIV_W-1:0]         num_x;
  logic [DIV_W-1:0]         num_y;
  logic                     div_start;
  logic                     busy_x;
  logic                     busy_y;
  logic [DIV_W-1:0]         quo_x;
  logic [DIV_W-1:0]         quo_y;
  logic [COPX_W-1:0]        mag_x;
  logic [COPY_W-1:0]        mag_y;
  logic signed [COPX_W-1:0] cop_x;
  logic signed [COPY_W-1:0] cop_y;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ram_we   = in_acc && in_word.read_ok &&
                    ({1'b0, in_word.sensor_index} < (IDX_W + 1)'(SENSOR_COUNT));

  fcop_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (ram_we),
    .wr_addr (in_word.sensor_index),
    .wr_data ({in_word.reply_high[1:0], in_word.reply_low}),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  always_comb begin
    prod_x = ACC_W'($signed({1'b0, rd_data}) * POS_X[acc_idx_r]);
    prod_y = ACC_W'($signed({1'b0, rd_data}) * POS_Y[acc_idx_r]);
    abs_x  = acc_x_r[ACC_W-1] ? ACC_W'(-acc_x_r) : ACC_W'(acc_x_r);
    abs_y  = acc_y_r[ACC_W-1] ? ACC_W'(-acc_y_r) : ACC_W'(acc_y_r);
    num_x  = DIV_W'({abs_x[ACC_W-2:0], {FRACTION_BITS{1'b0}}});
    num_y  = DIV_W'({abs_y[ACC_W-2:0], {FRACTION_BITS{1'b0}}});
  end

  assign div_start = (state_r == ST_CHECK) && (total_r > thr_r);

  fcop_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_x),
    .den   (total_r),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  fcop_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_y),
    .den   (total_r),
    .busy  (busy_y),
    .quo   (quo_y)
  );

  // saturate the quotient magnitude, then apply the sign
  always_comb begin
    if (neg_x_r) begin
      mag_x = (quo_x > DIV_W'(1024)) ? COPX_W'(1024) : quo_x[COPX_W-1:0];
    end else begin
      mag_x = (quo_x > DIV_W'(1023)) ? COPX_W'(1023) : quo_x[COPX_W-1:0];
    end
    if (neg_y_r) begin
      mag_y = (quo_y > DIV_W'(2048)) ? COPY_W'(2048) : quo_y[COPY_W-1:0];
    end else begin
      mag_y = (quo_y > DIV_W'(2047)) ? COPY_W'(2047) : quo_y[COPY_W-1:0];
    end
    if (!contact_r) begin
      cop_x = '0;
      cop_y = '0;
    end else begin
      cop_x = neg_x_r ? $signed(-mag_x) : $signed(mag_x);
      cop_y = neg_y_r ? $signed(-mag_y) : $signed(mag_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= TOTAL_W'(10);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_en_r <= (state_r == ST_SUM);
      if ((state_r == ST_PUT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          rd_idx_r <= '0;
          if (in_acc && in_word.end_of_frame) begin
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (rd_idx_r == IDX_W'(SENSOR_COUNT - 1)) begin
            state_r <= ST_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          state_r <= div_start ? ST_DIV : ST_PUT;
        end
        ST_DIV: begin
          if (!busy_x && !busy_y) begin
            state_r <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_idx_r <= rd_idx_r;
    if (state_r == ST_IDLE) begin
      total_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (acc_en_r) begin
      total_r <= total_r + TOTAL_W'(rd_data);
      acc_x_r <= acc_x_r + prod_x;
      acc_y_r <= acc_y_r + prod_y;
    end
    if (state_r == ST_CHECK) begin
      contact_r <= div_start;
      neg_x_r   <= acc_x_r[ACC_W-1];
      neg_y_r   <= acc_y_r[ACC_W-1];
    end
    if ((state_r == ST_PUT) && (!out_valid_r || !out_stall)) begin
      out_word_r.cop_x        <= cop_x;
      out_word_r.cop_y        <= cop_y;
      out_word_r.total_counts <= total_r;
      out_word_r.contact      <= contact_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/fcop_ram.sv
`timescale 1ns / 1ps
module fcop_ram
  import fcop_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ADC_W-1:0] wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ADC_W-1:0] rd_data
);

  logic [ADC_W-1:0]        mem [SENSOR_SLOTS];
  logic [SENSOR_SLOTS-1:0] valid_r;
  logic [ADC_W-1:0]        rd_data_r;

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/fcop_div.sv
`timescale 1ns / 1ps
module fcop_div
  import fcop_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   num,
  input  logic [TOTAL_W-1:0] den,
  output logic               busy,
  output logic [DIV_W-1:0]   quo
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [REM_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [REM_W-1:0]     rem_sh;
  logic                 ge;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r[REM_W-2:0], quo_r[DIV_W-1]};
    ge     = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

>>> dv/cop_monitor.sv
`timescale 1ns / 1ps
module cop_monitor
  import fcop_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [TOTAL_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  fcop_in_t           in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  fcop_out_t          out_word,
  output int                 fail_count,
  output int                 pending
);

  localparam int THRESHOLD_AT_RESET = 10;
  localparam int COPX_MIN = -(2 ** (COPX_W - 1));
  localparam int COPX_MAX = 2 ** (COPX_W - 1) - 1;
  localparam int COPY_MIN = -(2 ** (COPY_W - 1));
  localparam int COPY_MAX = 2 ** (COPY_W - 1) - 1;

  // sensor positions in mm
  localparam int X_MM [8] = '{-50, 50, -25, 25, -30, 30, -15, 15};
  localparam int Y_MM [8] = '{-100, -100, -50, -50, 0, 0, 50, 50};

  logic [ADC_W-1:0]   readings [8];
  logic [TOTAL_W-1:0] threshold;
  fcop_out_t          cop_due_q [$];

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // centroid of the stored readings; int division truncates toward zero
  function automatic fcop_out_t frame_cop();
    int total;
    int wx;
    int wy;
    int cx;
    int cy;
    fcop_out_t r;
    total = 0;
    wx = 0;
    wy = 0;
    cx = 0;
    cy = 0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      total += int'(readings[i]);
      wx += int'(readings[i]) * X_MM[i];
      wy += int'(readings[i]) * Y_MM[i];
    end
    r.contact = (total > int'(threshold));
    if (r.contact) begin
      cx = clamp((wx * (2 ** FRACTION_BITS)) / total, COPX_MIN, COPX_MAX);
      cy = clamp((wy * (2 ** FRACTION_BITS)) / total, COPY_MIN, COPY_MAX);
    end
    r.cop_x = cx[COPX_W-1:0];
    r.cop_y = cy[COPY_W-1:0];
    r.total_counts = total[TOTAL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    fcop_in_t  w;
    fcop_out_t want;
    if (!rst_n) begin
      foreach (readings[i]) readings[i] = '0;
      threshold = THRESHOLD_AT_RESET;
      cop_due_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (in_valid && !in_stall) begin
        w = in_word;
        if (w.read_ok && w.sensor_index < SENSOR_COUNT)
          readings[w.sensor_index] = {w.reply_high[1:0], w.reply_low};
        if (w.end_of_frame) cop_due_q.push_back(frame_cop());
      end
      if (out_valid && !out_stall) begin
        if (cop_due_q.size() == 0) begin
          $error("result word with none pending: cop_x %0d cop_y %0d total %0d contact %0d",
                 out_word.cop_x, out_word.cop_y, out_word.total_counts, out_word.contact);
          fail_count++;
        end else begin
          want = cop_due_q.pop_front();
          if (out_word.cop_x !== want.cop_x) begin
            $error("cop_x mismatch: expected %0d, actual %0d", want.cop_x, out_word.cop_x);
            fail_count++;
          end
          if (out_word.cop_y !== want.cop_y) begin
            $error("cop_y mismatch: expected %0d, actual %0d", want.cop_y, out_word.cop_y);
            fail_count++;
          end
          if (out_word.total_counts !== want.total_counts) begin
            $error("total_counts mismatch: expected %0d, actual %0d",
                   want.total_counts, out_word.total_counts);
            fail_count++;
          end
          if (out_word.contact !== want.contact) begin
            $error("contact mismatch: expected %0d, actual %0d", want.contact, out_word.contact);
            fail_count++;
          end
        end
      end
    end
    pending <= cop_due_q.size();
  end

endmodule

>>> dv/foot_center_of_pressure_unit_tb.sv
`timescale 1ns / 1ps
module foot_center_of_pressure_unit_tb;
  import fcop_pkg::*;

  localparam int SETTLE_CYCLES = SENSOR_COUNT + DIV_W + 12;
  localparam int STUCK_LIMIT   = 4000;
  localparam int PHASE_WORDS   = 110;
  localparam logic [9:0] ADC_MAX = 10'd1023;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [TOTAL_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  fcop_in_t           in_word;
  logic               out_valid;
  logic               out_stall;
  fcop_out_t          out_word;
  int                 fail_count;
  int                 pending;
  int                 stuck_cycles;
  bit                 in_calm;
  bit                 out_calm;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  foot_center_of_pressure_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  cop_monitor cop_mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  function automatic fcop_in_t sensor_word(logic [IDX_W-1:0] idx, logic [9:0] val,
                                           bit ok, bit eof);
    fcop_in_t w;
    w.sensor_index = idx;
    w.reply_high   = {6'($urandom), val[9:8]};  // upper reply bits are don't-care
    w.reply_low    = val[7:0];
    w.read_ok      = ok;
    w.end_of_frame = eof;
    return w;
  endfunction

  function automatic logic [9:0] any_reading();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ADC_MAX;
      2:       return 10'($urandom_range(0, 3));
      default: return 10'($urandom);
    endcase
  endfunction

  // valid stays up when the next word follows with no gap
  task automatic send_word(input fcop_in_t w);
    int gap;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    gap = in_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [TOTAL_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_traffic(input int n_words);
    int sent;
    int cnt;
    bit sparse;
    bit shuffled;
    fcop_in_t w;
    sent = 0;
    while (sent < n_words) begin
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        7, 8: begin
          // noise word, every field random
          w = fcop_in_t'($bits(fcop_in_t)'($urandom));
          send_word(w);
          sent++;
        end
        9: begin
          // broken frame: a few reads, no frame end
          cnt = $urandom_range(1, 7);
          for (int i = 0; i < cnt; i++)
            send_word(sensor_word(IDX_W'($urandom), any_reading(), $urandom_range(0, 3) != 0,
                                  1'b0));
          sent += cnt;
        end
        default: begin
          sparse   = ($urandom_range(0, 3) == 0);
          shuffled = ($urandom_range(0, 3) == 0);
          for (int s = 0; s < SENSOR_COUNT; s++)
            send_word(sensor_word(shuffled ? IDX_W'($urandom) : IDX_W'(s),
                                  (sparse && $urandom_range(0, 3) != 0) ? 10'd0 : any_reading(),
                                  $urandom_range(0, 7) != 0, s == SENSOR_COUNT - 1));
          sent += SENSOR_COUNT;
        end
      endcase
    end
  endtask

  // result side: stall a random number of cycles, then take one word
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = out_calm ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [TOTAL_W-1:0] thresholds [8];
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_word     = '0;
    in_calm     = 1'b0;
    out_calm    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset threshold of 10: empty store, total on the threshold, just above it
    send_word(sensor_word(IDX_W'(0), ADC_MAX, 1'b0, 1'b1));
    send_word(sensor_word(IDX_W'(0), 10'd10, 1'b1, 1'b1));
    send_word(sensor_word(IDX_W'(1), 10'd1, 1'b1, 1'b1));
    // failed read keeps the old value
    send_word(sensor_word(IDX_W'(0), ADC_MAX, 1'b0, 1'b1));
    // full scale on every sensor, upper reply bits set
    for (int s = 0; s < 8; s++)
      send_word('{sensor_index: IDX_W'(s), reply_high: 8'hFF, reply_low: 8'hFF,
                  read_ok: 1'b1, end_of_frame: s == 7});
    // one sensor loaded at a time: sensor 0 (rear-left corner), then 1, then 7
    for (int s = 1; s < 8; s++)
      send_word(sensor_word(IDX_W'(s), 10'd0, 1'b1, s == 7));
    send_word(sensor_word(IDX_W'(0), 10'd0, 1'b1, 1'b0));
    send_word(sensor_word(IDX_W'(1), ADC_MAX, 1'b1, 1'b1));
    send_word(sensor_word(IDX_W'(1), 10'd0, 1'b1, 1'b0));
    send_word(sensor_word(IDX_W'(7), ADC_MAX, 1'b1, 1'b1));

    thresholds = '{13'd0, 13'd8184, 13'd8183, 13'h1FFF, 13'd1,
                   13'($urandom_range(0, 200)), 13'($urandom), 13'd10};
    foreach (thresholds[p]) begin
      go_idle();
      write_threshold(thresholds[p]);
      run_traffic(PHASE_WORDS);
    end
    go_idle();

    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
